// ===== rtl/core/cle_pkg.sv =====
// Shared types, codes and defaults of the cursor list engine.
`default_nettype none

package cle_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [3:0] {
    CMD_CLEAR  = 4'd0,
    CMD_APPEND = 4'd1,
    CMD_INSERT = 4'd2,
    CMD_REMOVE = 4'd3,
    CMD_START  = 4'd4,
    CMD_END    = 4'd5,
    CMD_PREV   = 4'd6,
    CMD_NEXT   = 4'd7,
    CMD_MOVE   = 4'd8,
    CMD_READ   = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] value;
    logic [5:0]  position;
  } in_req_t;

  typedef struct packed {
    logic [31:0] value_out;
    logic [6:0]  count;
    logic [5:0]  cursor_pos;
    logic [1:0]  status;
  } out_rsp_t;

  // Controller to datapath commands, at most one high per cycle.
  typedef struct packed {
    logic accept;
    logic ins_read;
    logic ins_write;
    logic ins_final;
    logic rd_capture;
    logic rm_read;
    logic rm_write;
    logic rm_final;
    logic out_load;
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic long_ins;
    logic long_rd;
    logic req_remove;
    logic ptr_eq_cur;
    logic rm_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/cle_datapath.sv =====
// Datapath: element memory, fill count, cursor, shift pointer and result register.
`default_nettype none

module cle_datapath #(
  parameter int unsigned CAPACITY   = cle_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = cle_pkg::DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cle_pkg::in_req_t     in_req_i,
  input  cle_pkg::ctl_cmd_t    cmd_i,
  output cle_pkg::dp_status_t  status_o,
  output cle_pkg::out_rsp_t    out_rsp_o
);
  import cle_pkg::*;

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > 6) ? CW : 6;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_q;

  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         cursor_q, cursor_d;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [3:0]            cmd_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [DATA_WIDTH-1:0] res_q, res_d;
  out_rsp_t              out_q, out_d;

  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  logic                  full, empty;
  logic [DATA_WIDTH-1:0] in_val;
  logic [CMPW-1:0]       pos_ext, cnt_ext;
  logic [CW-1:0]         imm_count;
  logic [AW-1:0]         imm_cursor;
  status_e               imm_status;
  logic                  imm_wr, long_ins, long_rd;

  assign full    = (count_q == CW'(CAPACITY));
  assign empty   = (count_q == '0);
  assign in_val  = DATA_WIDTH'(in_req_i.value);
  assign pos_ext = CMPW'(in_req_i.position);
  assign cnt_ext = CMPW'(count_q);

  // Decode the incoming request against the current state.
  always_comb begin
    imm_count  = count_q;
    imm_cursor = cursor_q;
    imm_status = ST_OK;
    imm_wr     = 1'b0;
    long_ins   = 1'b0;
    long_rd    = 1'b0;
    unique case (cmd_e'(in_req_i.cmd)) inside
      CMD_CLEAR: begin
        imm_count  = '0;
        imm_cursor = '0;
      end
      CMD_APPEND: begin
        if (full) begin
          imm_status = ST_FULL;
        end else begin
          imm_wr    = 1'b1;
          imm_count = count_q + CW'(1);
        end
      end
      CMD_INSERT: begin
        if (full) imm_status = ST_FULL;
        else      long_ins   = 1'b1;
      end
      CMD_REMOVE, CMD_READ: begin
        if (empty) imm_status = ST_EMPTY;
        else       long_rd    = 1'b1;
      end
      CMD_START: imm_cursor = '0;
      CMD_END: begin
        imm_cursor = empty ? '0 : AW'(count_q - CW'(1));
      end
      CMD_PREV: begin
        if (cursor_q != '0) imm_cursor = cursor_q - AW'(1);
      end
      CMD_NEXT: begin
        if ((CW'(cursor_q) + CW'(1)) < count_q) imm_cursor = cursor_q + AW'(1);
      end
      CMD_MOVE: begin
        if (pos_ext < cnt_ext) imm_cursor = AW'(pos_ext);
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    ptr_d    = ptr_q;
    res_d    = res_q;
    out_d    = out_q;
    rd_en    = 1'b0;
    rd_addr  = cursor_q;
    wr_en    = 1'b0;
    wr_addr  = ptr_q;
    wr_data  = rdata_q;

    if (cmd_i.accept) begin
      count_d  = imm_count;
      cursor_d = imm_cursor;
      res_d    = '0;
      ptr_d    = AW'(count_q);
      if (imm_wr) begin
        wr_en   = 1'b1;
        wr_addr = AW'(count_q);
        wr_data = in_val;
      end
      if (long_rd) begin
        rd_en   = 1'b1;
        rd_addr = cursor_q;
      end
      if (!(long_ins || long_rd)) begin
        out_d.value_out  = '0;
        out_d.count      = 7'(imm_count);
        out_d.cursor_pos = 6'(imm_cursor);
        out_d.status     = imm_status;
      end
    end

    if (cmd_i.ins_read) begin
      rd_en   = 1'b1;
      rd_addr = ptr_q - AW'(1);
    end
    if (cmd_i.ins_write) begin
      wr_en = 1'b1;
      ptr_d = ptr_q - AW'(1);
    end
    if (cmd_i.ins_final) begin
      wr_en   = 1'b1;
      wr_data = value_q;
      count_d = count_q + CW'(1);
    end

    if (cmd_i.rd_capture) begin
      res_d = rdata_q;
      ptr_d = cursor_q;
    end
    if (cmd_i.rm_read) begin
      rd_en   = 1'b1;
      rd_addr = ptr_q + AW'(1);
    end
    if (cmd_i.rm_write) begin
      wr_en = 1'b1;
      ptr_d = ptr_q + AW'(1);
    end
    if (cmd_i.rm_final) begin
      count_d = count_q - CW'(1);
      // Only element gone: home; last element gone: step back.
      if (count_q == CW'(1)) begin
        cursor_d = '0;
      end else if (CW'(cursor_q) == (count_q - CW'(1))) begin
        cursor_d = cursor_q - AW'(1);
      end
    end

    if (cmd_i.out_load) begin
      out_d.value_out  = 32'(res_q);
      out_d.count      = 7'(count_q);
      out_d.cursor_pos = 6'(cursor_q);
      out_d.status     = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    res_q <= res_d;
    out_q <= out_d;
    if (cmd_i.accept) begin
      cmd_q   <= in_req_i.cmd;
      value_q <= in_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  assign status_o.long_ins   = long_ins;
  assign status_o.long_rd    = long_rd;
  assign status_o.req_remove = (cmd_q == CMD_REMOVE);
  assign status_o.ptr_eq_cur = (ptr_q == cursor_q);
  assign status_o.rm_last    = (CW'(ptr_q) + CW'(1)) >= count_q;
  assign out_rsp_o           = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/cle_ctrl.sv =====
// Controller: request sequencing, shift loops and result handshake.
`default_nettype none

module cle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  cle_pkg::dp_status_t status_i,
  output cle_pkg::ctl_cmd_t   cmd_o
);
  import cle_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_INS     = 7'b0000010,
    S_INS_WR  = 7'b0000100,
    S_RD_WAIT = 7'b0001000,
    S_RM      = 7'b0010000,
    S_RM_WR   = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free, accept;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = (state_q == S_IDLE) && in_valid_i && out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (status_i.long_ins)     state_d = S_INS;
          else if (status_i.long_rd) state_d = S_RD_WAIT;
        end
      end
      S_INS: begin
        if (status_i.ptr_eq_cur) begin
          cmd_o.ins_final = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.ins_read = 1'b1;
          state_d        = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.ins_write = 1'b1;
        state_d         = S_INS;
      end
      S_RD_WAIT: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = status_i.req_remove ? S_RM : S_DONE;
      end
      S_RM: begin
        if (status_i.rm_last) begin
          cmd_o.rm_final = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.rm_read = 1'b1;
          state_d       = S_RM_WR;
        end
      end
      S_RM_WR: begin
        cmd_o.rm_write = 1'b1;
        state_d        = S_RM;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Set on a loaded result, drop when taken.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if ((cmd_o.accept && !(status_i.long_ins || status_i.long_rd)) || cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE) || !out_free;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/cursor_list_engine_top.sv =====
// Top level of the cursor list engine: controller and datapath.
`default_nettype none

// Bounded ordered list of up to CAPACITY elements with a cursor. Each request
// carries a command (clear, append, insert before the cursor, remove at the
// cursor, move to start or end, previous, next, move to a position, read) and
// produces exactly one result with the removed or read element, the element
// count, the cursor position and a status (ok, full, empty). Elements live in
// a single-port-style memory with one write and one registered read per
// cycle. Clear, append, cursor moves, unused codes and all error cases finish
// in the accepting cycle, so such requests go through at one per cycle while
// the result side does not stall. Read passes through a read-wait and a done
// state. On insert and remove every element behind the cursor moves by one
// read followed by one write of the memory. A result waits in an output
// register; a new request is taken while the previous result is taken in the
// same cycle. No clearing pass is needed after reset: only elements below the
// count are ever read.

module cursor_list_engine_top #(
  parameter int unsigned CAPACITY   = cle_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = cle_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cle_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cle_pkg::out_rsp_t out_rsp_o
);
  import cle_pkg::*;

  ctl_cmd_t   ctl_cmd;
  dp_status_t dp_status;

  // Sequence requests and own both handshakes.
  cle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (ctl_cmd)
  );

  // Hold the elements, count and cursor; shift on insert and remove.
  cle_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (ctl_cmd),
    .status_o  (dp_status),
    .out_rsp_o (out_rsp_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cle_checker.sv =====
// Port-level checks of the cursor list engine and their bind.
`default_nettype none

module cle_checker #(
  parameter int unsigned CAPACITY = cle_pkg::CAPACITY_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input cle_pkg::out_rsp_t out_rsp_o
);
  import cle_pkg::*;

  localparam logic NARROW = (CAPACITY <= 64);

  // A waiting result must block new requests.
  a_stall_on_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request accepted while result pending");

  // Cursor stays inside the list, or at zero when empty.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && NARROW |->
      ((out_rsp_o.count == 7'd0) ? (out_rsp_o.cursor_pos == 6'd0)
                                 : (7'(out_rsp_o.cursor_pos) < out_rsp_o.count)))
    else $error("cursor outside list");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && NARROW |-> out_rsp_o.count <= 7'(CAPACITY))
    else $error("count above capacity");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

endmodule

bind cursor_list_engine_top cle_checker #(.CAPACITY(CAPACITY)) u_cle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the cursor list engine: directed request table, then random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cle_pkg::*;

  localparam int unsigned CAP          = CAPACITY_DEF;
  localparam int unsigned RANDOM_REQS  = 1030;
  // Hold the result side off once, after this many results, so the engine backs up.
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_OFF     = 250;
  // Longest insert or remove shifts every element once.
  localparam int unsigned DRAIN_CYCLES = 2 * CAP + 20;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned BOUND_VISITS = 3;
  localparam logic [3:0]  CMD_SPARE_LO = 4'd10;
  localparam logic [3:0]  CMD_SPARE_HI = 4'd15;

  typedef enum logic [1:0] {
    PH_GROW,
    PH_SHRINK,
    PH_WANDER
  } traffic_phase_e;

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_rsp_t rsp;
  } plan_row_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_rsp;

  // Shadow copy of the list, advanced once per accepted request.
  logic [31:0] shadow_cells [CAP];
  logic [6:0]  shadow_count  = '0;
  logic [5:0]  shadow_cursor = '0;

  out_rsp_t    pending_rsp_q [$];
  plan_row_t   directed_plan [$];

  int unsigned    error_count  = 0;
  int unsigned    results_seen = 0;
  int unsigned    idle_cycles  = 0;
  int unsigned    burst_left   = 0;
  traffic_phase_e phase        = PH_GROW;
  int unsigned    phase_left   = 300;
  int unsigned    bound_hits   = 0;

  cursor_list_engine_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold reset, then release it away from the rising edge.
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Apply one request to the shadow list and return the result it must produce.
  function automatic out_rsp_t list_apply(input in_req_t req);
    out_rsp_t rsp;
    int       i;
    rsp        = '0;
    rsp.status = ST_OK;
    case (req.cmd)
      CMD_CLEAR: begin
        shadow_count  = '0;
        shadow_cursor = '0;
      end
      CMD_APPEND: begin
        if (shadow_count >= CAP) begin
          rsp.status = ST_FULL;
        end else begin
          shadow_cells[shadow_count] = req.value;
          shadow_count++;
        end
      end
      CMD_INSERT: begin
        if (shadow_count >= CAP) begin
          rsp.status = ST_FULL;
        end else begin
          if (shadow_cursor > shadow_count) shadow_cursor = shadow_count[5:0];
          for (i = shadow_count; i > shadow_cursor; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[shadow_cursor] = req.value;
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        if (shadow_count == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          if (shadow_cursor >= shadow_count) shadow_cursor = 6'(shadow_count - 1);
          rsp.value_out = shadow_cells[shadow_cursor];
          for (i = shadow_cursor; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_count--;
          // Step back off the end, snap home when the list runs dry.
          if (shadow_count == 0) shadow_cursor = '0;
          else if (shadow_cursor == shadow_count) shadow_cursor--;
        end
      end
      CMD_START: shadow_cursor = '0;
      CMD_END:   shadow_cursor = (shadow_count != 0) ? 6'(shadow_count - 1) : '0;
      CMD_PREV:  if (shadow_cursor > 0) shadow_cursor--;
      CMD_NEXT:  if (shadow_cursor + 1 < shadow_count) shadow_cursor++;
      CMD_MOVE:  if (req.position < shadow_count) shadow_cursor = req.position;
      CMD_READ: begin
        if (shadow_count == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          if (shadow_cursor >= shadow_count) shadow_cursor = 6'(shadow_count - 1);
          rsp.value_out = shadow_cells[shadow_cursor];
        end
      end
      default: ;
    endcase
    rsp.count      = shadow_count;
    rsp.cursor_pos = shadow_cursor;
    return rsp;
  endfunction

  function automatic void add_row(input logic [3:0] cmd, input logic [31:0] value,
                                  input logic [5:0] position, input bit typed = 1'b0,
                                  input logic [31:0] exp_value = '0,
                                  input logic [6:0] exp_count = '0,
                                  input logic [5:0] exp_cursor = '0,
                                  input status_e exp_status = ST_OK);
    plan_row_t row;
    row.req.cmd        = cmd;
    row.req.value      = value;
    row.req.position   = position;
    row.typed          = typed;
    row.rsp.value_out  = exp_value;
    row.rsp.count      = exp_count;
    row.rsp.cursor_pos = exp_cursor;
    row.rsp.status     = exp_status;
    directed_plan.push_back(row);
  endfunction

  // Draw the next random request. Grow and shrink phases walk the list to full
  // and to empty and poke at the bound a few times; wander phases mix everything.
  function automatic in_req_t next_random_req();
    in_req_t     req;
    int unsigned pick;
    if (phase_left == 0 || bound_hits >= BOUND_VISITS) begin
      phase      = traffic_phase_e'($urandom_range(0, 2));
      phase_left = (phase == PH_WANDER) ? $urandom_range(20, 80) : 300;
      bound_hits = 0;
    end
    phase_left--;
    if ((phase == PH_GROW && shadow_count == CAP) || (phase == PH_SHRINK && shadow_count == 0))
      bound_hits++;

    req.value    = $urandom;
    req.position = 6'($urandom_range(0, 63));
    pick         = $urandom_range(0, 99);
    case (phase)
      PH_GROW: begin
        if (pick < 45)      req.cmd = CMD_APPEND;
        else if (pick < 78) req.cmd = CMD_INSERT;
        else if (pick < 86) req.cmd = CMD_MOVE;
        else if (pick < 90) req.cmd = CMD_READ;
        else if (pick < 94) req.cmd = CMD_PREV;
        else if (pick < 97) req.cmd = CMD_NEXT;
        else                req.cmd = CMD_END;
      end
      PH_SHRINK: begin
        if (pick < 55)      req.cmd = CMD_REMOVE;
        else if (pick < 65) req.cmd = CMD_READ;
        else if (pick < 75) req.cmd = CMD_MOVE;
        else if (pick < 82) req.cmd = CMD_PREV;
        else if (pick < 89) req.cmd = CMD_NEXT;
        else if (pick < 94) req.cmd = CMD_START;
        else                req.cmd = CMD_END;
      end
      default: begin
        if (pick < 3)      req.cmd = CMD_CLEAR;
        else if (pick < 9) req.cmd = 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        else               req.cmd = 4'($urandom_range(int'(CMD_APPEND), int'(CMD_READ)));
      end
    endcase
    // Keep most moves in range outside the wander phase.
    if (phase != PH_WANDER && req.cmd == CMD_MOVE && shadow_count != 0)
      req.position = 6'($urandom_range(0, shadow_count - 1));
    return req;
  endfunction

  // Offer one request until taken, then record what it must return.
  // Idle for a random gap at the start of each burst.
  task automatic send_req(input in_req_t req, input bit typed, input out_rsp_t typed_rsp);
    out_rsp_t    predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req   <= req;
    do begin
      @(posedge clk);
    end while (in_stall);
    predicted = list_apply(req);
    pending_rsp_q.push_back(typed ? typed_rsp : predicted);
    @(negedge clk);
  endtask

  function automatic void log_failure(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
  endfunction

  initial begin : stimulus
    in_req_t req;

    // Empty list corner cases first.
    add_row(CMD_READ,   32'h0, 6'd0,  1'b1, 32'h0, 7'd0, 6'd0, ST_EMPTY);
    add_row(CMD_REMOVE, 32'h0, 6'd0,  1'b1, 32'h0, 7'd0, 6'd0, ST_EMPTY);
    add_row(CMD_END,    32'h0, 6'd0,  1'b1, 32'h0, 7'd0, 6'd0, ST_OK);
    add_row(CMD_PREV,   32'h0, 6'd0,  1'b1, 32'h0, 7'd0, 6'd0, ST_OK);
    add_row(CMD_MOVE,   32'h0, 6'h3f, 1'b1, 32'h0, 7'd0, 6'd0, ST_OK);
    // Build a short list, insert ahead of the cursor and read the new element back.
    add_row(CMD_APPEND, 32'hffff_ffff, 6'd0, 1'b1, 32'h0, 7'd1, 6'd0, ST_OK);
    add_row(CMD_APPEND, 32'h0000_0000, 6'd0, 1'b1, 32'h0, 7'd2, 6'd0, ST_OK);
    add_row(CMD_INSERT, 32'ha5a5_a5a5, 6'd0, 1'b1, 32'h0, 7'd3, 6'd0, ST_OK);
    add_row(CMD_READ,   32'h0, 6'd0, 1'b1, 32'ha5a5_a5a5, 7'd3, 6'd0, ST_OK);
    // Walk the cursor; next at the last element must hold.
    add_row(CMD_NEXT,   32'h0, 6'd0);
    add_row(CMD_READ,   32'h0, 6'd0);
    add_row(CMD_END,    32'h0, 6'd0);
    add_row(CMD_NEXT,   32'h0, 6'd0);
    add_row(CMD_INSERT, 32'h5a5a_5a5a, 6'd0);
    add_row(CMD_MOVE,   32'h0, 6'd3);
    // Remove at the tail steps the cursor back.
    add_row(CMD_REMOVE, 32'h0, 6'd0);
    add_row(CMD_MOVE,   32'h0, 6'd0);
    add_row(CMD_SPARE_HI, 32'hdead_beef, 6'h3f);
    add_row(CMD_SPARE_LO, 32'h1234_5678, 6'd1);
    add_row(CMD_START,  32'h0, 6'd0);
    add_row(CMD_REMOVE, 32'h0, 6'd0);
    add_row(CMD_CLEAR,  32'h0, 6'd0, 1'b1, 32'h0, 7'd0, 6'd0, ST_OK);
    // Removing the only element sends the cursor home.
    add_row(CMD_APPEND, 32'h8000_0001, 6'd0, 1'b1, 32'h0, 7'd1, 6'd0, ST_OK);
    add_row(CMD_REMOVE, 32'h0, 6'd0, 1'b1, 32'h8000_0001, 7'd0, 6'd0, ST_OK);

    @(posedge rst_n);
    @(negedge clk);
    foreach (directed_plan[k])
      send_req(directed_plan[k].req, directed_plan[k].typed, directed_plan[k].rsp);

    // Random traffic opens with a grow phase, so the full list is reached early.
    repeat (RANDOM_REQS) begin
      req = next_random_req();
      send_req(req, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then give the engine time to show any stray one.
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Stall the result side on a changing pattern: open stretches, light and heavy
  // random stalls, a regular beat, and one long hold-off that backs up the engine.
  initial begin : result_stall
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          held;
    mode_left = 0;
    hold_left = 0;
    held      = 1'b0;
    mode      = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && results_seen >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_OFF - 1;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (mode_left % 4 == 0);
        endcase
      end
    end
  end

  // Compare every accepted result with the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_rsp_q.size() == 0) begin
        log_failure($sformatf("result %0d arrived with no request outstanding", results_seen));
      end else begin
        want = pending_rsp_q.pop_front();
        if (out_rsp.value_out  !== want.value_out  || out_rsp.count  !== want.count ||
            out_rsp.cursor_pos !== want.cursor_pos || out_rsp.status !== want.status)
          log_failure($sformatf({"result %0d mismatch: value_out exp %h got %h, count exp %0d ",
                                 "got %0d, cursor exp %0d got %0d, status exp %0d got %0d"},
                                results_seen, want.value_out, out_rsp.value_out,
                                want.count, out_rsp.count, want.cursor_pos,
                                out_rsp.cursor_pos, want.status, out_rsp.status));
      end
    end
  end

  // Abort when neither side moves for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
